/* hw/rtl/nbbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAND bad-block skip translation package
// Geometry constants, field widths, command codes, sequencer states and the
// result record shared by the translation core and its submodules.
// ----------------------------------------------------------------------------
package nbbs_pkg;

  // Device geometry. All sizes are powers of two, so block, page and plane
  // numbers are bit fields of the byte address.
  localparam int PAGE_BYTES       = 2048;
  localparam int PAGES_PER_BLOCK  = 64;
  localparam int BLOCKS_PER_PLANE = 1024;
  localparam int TOTAL_BLOCKS     = 2048;
  localparam int FIRST_DATA_BLOCK = 1;

  localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
  localparam int BLOCK_SHIFT = PAGE_SHIFT + $clog2(PAGES_PER_BLOCK);
  localparam int PLANE_SHIFT = BLOCK_SHIFT + $clog2(BLOCKS_PER_PLANE);
  localparam longint BLOCK_BYTES = longint'(PAGE_BYTES) * longint'(PAGES_PER_BLOCK);

  // Field widths of the item channels.
  localparam int BLOCK_IDX_W = 11;
  localparam int LADDR_W     = 32;
  localparam int PADDR_W     = 28;
  localparam int BIP_W       = 10;
  localparam int PIB_W       = 6;

  // Command codes.
  localparam logic CMD_MARK  = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PADDR_W-1:0] physical_address;
    logic               plane_number;
    logic [BIP_W-1:0]   block_in_plane;
    logic [PIB_W-1:0]   page_in_block;
    logic               memory_full;
  } result_t;

endpackage

/* hw/rtl/nbbs_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAND bad-block skip translation channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface nbbs_in_if;
  import nbbs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [BLOCK_IDX_W-1:0] block_index;
  logic                   block_good;
  logic [LADDR_W-1:0]     logical_address;

  modport source (
    output valid, cmd, block_index, block_good, logical_address,
    input  ready
  );
  modport sink (
    input  valid, cmd, block_index, block_good, logical_address,
    output ready
  );
endinterface

interface nbbs_out_if;
  import nbbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [PADDR_W-1:0] physical_address;
  logic               plane_number;
  logic [BIP_W-1:0]   block_in_plane;
  logic [PIB_W-1:0]   page_in_block;
  logic               memory_full;

  modport source (
    output valid, physical_address, plane_number, block_in_plane, page_in_block,
           memory_full,
    input  ready
  );
  modport sink (
    input  valid, physical_address, plane_number, block_in_plane, page_in_block,
           memory_full,
    output ready
  );
endinterface

/* hw/rtl/nbbs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nbbs_ram #(
  parameter  int Width = 1,
  parameter  int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/nbbs_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAND bad-block skip translation sequencer
// Clears the good-block map after reset, applies mark items and walks the map
// for translate items, one entry per cycle, then formats the result.
// ----------------------------------------------------------------------------
module nbbs_seq #(
  parameter  int TotalBlocks = nbbs_pkg::TOTAL_BLOCKS,
  localparam int IdxW        = $clog2(TotalBlocks)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [nbbs_pkg::BLOCK_IDX_W-1:0]    block_index_i,
  input  logic                                block_good_i,
  input  logic [nbbs_pkg::LADDR_W-1:0]        logical_address_i,
  output logic                                res_valid_o,
  input  logic                                res_take_i,
  output nbbs_pkg::result_t                   res_o,
  output logic                                mem_we_o,
  output logic [IdxW-1:0]                     mem_waddr_o,
  output logic                                mem_wdata_o,
  output logic [IdxW-1:0]                     mem_raddr_o,
  input  logic                                mem_rdata_i
);
  import nbbs_pkg::*;

  localparam int IdxW1  = IdxW + 1;
  localparam int AddrW  = BLOCK_SHIFT + IdxW;
  localparam int AddrW1 = AddrW + 1;
  localparam logic [63:0] MemBytes = 64'(TotalBlocks) << BLOCK_SHIFT;
  localparam logic [AddrW-1:0]  LastPage  = AddrW'(MemBytes - 64'(PAGE_BYTES));
  localparam logic [AddrW1-1:0] BlockStep = AddrW1'(BLOCK_BYTES);
  localparam logic [IdxW1-1:0]  FirstIdx  = IdxW1'(FIRST_DATA_BLOCK);
  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(TotalBlocks - 1);

  // Width wide enough for every bit field taken from the address.
  localparam int XwA = (AddrW > PADDR_W) ? AddrW : PADDR_W;
  localparam int XwB = (XwA > PLANE_SHIFT + 1) ? XwA : PLANE_SHIFT + 1;
  localparam int XwC = (XwB > BLOCK_SHIFT + BIP_W) ? XwB : BLOCK_SHIFT + BIP_W;
  localparam int XW  = (XwC > PAGE_SHIFT + PIB_W) ? XwC : PAGE_SHIFT + PIB_W;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic              full_q, full_d;
  logic [IdxW1-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic              chk_v_q, chk_v_d;
  logic [IdxW-1:0]   clr_q, clr_d;

  logic [IdxW-1:0]   target;
  logic [AddrW1-1:0] next_addr;
  logic              next_full;
  logic              laddr_over;
  logic              laddr_early;
  logic [XW-1:0]     addr_x;

  assign target      = addr_q[AddrW-1:BLOCK_SHIFT];
  assign next_addr   = {1'b0, addr_q} + BlockStep;
  assign next_full   = 64'(next_addr) >= MemBytes;
  assign laddr_over  = 64'(logical_address_i) >= MemBytes;
  assign laddr_early = (64'(logical_address_i) >> BLOCK_SHIFT) < 64'(FIRST_DATA_BLOCK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      chk_v_q <= chk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    full_q    <= full_d;
    idx_q     <= idx_d;
    chk_idx_q <= chk_idx_d;
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    full_d      = full_q;
    idx_d       = idx_q;
    chk_idx_d   = chk_idx_q;
    chk_v_d     = chk_v_q;
    clr_d       = clr_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = clr_q;
    mem_wdata_o = 1'b1;
    mem_raddr_o = idx_q[IdxW-1:0];

    case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_DONE;
          if (cmd_i == CMD_MARK) begin
            mem_we_o    = 32'(block_index_i) < 32'(TotalBlocks);
            mem_waddr_o = IdxW'(block_index_i);
            mem_wdata_o = block_good_i;
            addr_d      = '0;
            full_d      = 1'b0;
          end else if (laddr_over) begin
            addr_d = LastPage;
            full_d = 1'b1;
          end else begin
            addr_d  = AddrW'(logical_address_i);
            full_d  = 1'b0;
            idx_d   = FirstIdx;
            chk_v_d = 1'b0;
            if (!laddr_early) begin
              state_d = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        // A read is issued every cycle; the entry read last cycle is checked now.
        idx_d     = idx_q + 1'b1;
        chk_idx_d = idx_q[IdxW-1:0];
        chk_v_d   = 1'b1;
        if (chk_v_q) begin
          if (!mem_rdata_i) begin
            if (next_full) begin
              full_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              addr_d = next_addr[AddrW-1:0];
            end
          end else if (chk_idx_q == target) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    addr_x                 = XW'(addr_q);
    res_o.physical_address = addr_x[PADDR_W-1:0];
    res_o.plane_number     = addr_x[PLANE_SHIFT];
    res_o.block_in_plane   = addr_x[BLOCK_SHIFT +: BIP_W];
    res_o.page_in_block    = addr_x[PAGE_SHIFT +: PIB_W];
    res_o.memory_full      = full_q;
  end

  // The entry being checked never lies past the current target block.
  a_chk_within_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && chk_v_q) |-> (chk_idx_q <= target))
    else $error("walk checks an entry past the target block");

  // A walk keeps the pushed address below the memory size.
  a_addr_in_memory: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (64'(addr_q) < MemBytes))
    else $error("walk address reached the memory size");

  // The map is never written while a walk may read it.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_DONE) |-> !mem_we_o)
    else $error("map written during a walk");

  // A finished result waits unchanged until the output stage takes it.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_take_i) |=> (res_valid_o && $stable(res_o)))
    else $error("pending result changed before it was taken");

endmodule

/* hw/rtl/nand_bad_block_skip_translate_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NAND bad-block skip translation core
// Good/bad block map with logical-to-physical address translation that skips
// bad blocks, returning the physical address and its plane/block/page split.
// ----------------------------------------------------------------------------
// After reset the core writes every entry of its good-block map to "good";
// in_i.ready stays low during this clearing pass. It then takes one item at
// a time and returns exactly one result item per input item. A mark item
// (cmd 0) writes one map entry in the cycle it is accepted and returns an
// all-zero result through the done state and the output register; a block
// index at or beyond TotalBlocks is ignored. A translate item (cmd 1) walks
// the map from the first data block up to the block its address falls in,
// one map entry per cycle through the map RAM's registered read port; each
// bad block pushes the address forward one block and lengthens the walk. A
// walk visits at most TotalBlocks - 1 map entries. An address below the first
// data block is returned unchanged without a walk. Addresses at or beyond the
// memory size return the start of the last page with memory_full set. A walk
// that would push the address to the memory size stops and returns the
// address held before that push, also with memory_full set.
// The finished result goes into an output register, so the core accepts the
// next item while a result still waits on out_o.ready. The map is written only
// by the clearing pass and by mark items, never during a walk, so no
// forwarding between the write and read ports is needed.
// ----------------------------------------------------------------------------
module nand_bad_block_skip_translate_core #(
  parameter int TotalBlocks = nbbs_pkg::TOTAL_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nbbs_in_if.sink     in_i,
  nbbs_out_if.source  out_o
);
  import nbbs_pkg::*;

  localparam int IdxW = $clog2(TotalBlocks);

  // Sequencer to map RAM.
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic            mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic            mem_rdata;

  // Sequencer to output stage.
  logic    res_valid;
  logic    res_take;
  result_t res;

  // Output register.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  nbbs_ram #(
    .Width (1),
    .Depth (TotalBlocks)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nbbs_seq #(
    .TotalBlocks (TotalBlocks)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_i.valid),
    .in_ready_o        (in_i.ready),
    .cmd_i             (in_i.cmd),
    .block_index_i     (in_i.block_index),
    .block_good_i      (in_i.block_good),
    .logical_address_i (in_i.logical_address),
    .res_valid_o       (res_valid),
    .res_take_i        (res_take),
    .res_o             (res),
    .mem_we_o          (mem_we),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  // The output register loads a new result whenever it is empty or its
  // current item is leaving in the same cycle.
  assign res_take    = res_valid && (!out_valid_q || out_o.ready);
  assign out_valid_d = res_take || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.physical_address = out_q.physical_address;
  assign out_o.plane_number     = out_q.plane_number;
  assign out_o.block_in_plane   = out_q.block_in_plane;
  assign out_o.page_in_block    = out_q.page_in_block;
  assign out_o.memory_full      = out_q.memory_full;

  // A result is only moved into an output register that is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over an item not yet taken");

  // A result that was handed over appears on the output in the next cycle.
  a_take_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> (out_valid_q && out_q == $past(res)))
    else $error("taken result not shown on the output");

  // No new item is taken while a result is still pending inside the core.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_i.ready)
    else $error("item accepted while a result is pending");

endmodule
